/* rtl/core/bbuart_pkg.sv */
// ----------------------------------------------------------------------------
// Bit-bang UART transceiver package
// Shared widths, reset values and state encodings for the 8N1 transceiver.
// ----------------------------------------------------------------------------
package bbuart_pkg;

  localparam int DATA_BITS   = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int PERIOD_W    = 16;
  localparam int BIT_IDX_W   = $clog2(DATA_BITS);

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(104);
  localparam logic [PERIOD_W-1:0]  PERIOD_MIN   = PERIOD_W'(2);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT     = BIT_IDX_W'(DATA_BITS - 1);

  // Transmit frame sequencer.
  typedef enum logic [3:0] {
    TX_IDLE  = 4'b0001,
    TX_START = 4'b0010,
    TX_DATA  = 4'b0100,
    TX_STOP  = 4'b1000
  } tx_state_t;

  // Receive sequencer.
  typedef enum logic [2:0] {
    RX_IDLE = 3'b001,
    RX_DATA = 3'b010,
    RX_WAIT = 3'b100
  } rx_state_t;

endpackage

/* rtl/core/bitbang_uart_transceiver_unit.sv */
// ----------------------------------------------------------------------------
// Bit-bang UART transceiver unit
// 8N1 serial transmitter and polling receiver stepped by one tick per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Every input transfer is one timing tick, normally driven from a baud-rate
//   enable. It carries the sampled receive line level, an optional byte to
//   send and a counter clear. Every input transfer yields exactly one output
//   transfer holding the transmit line drive, busy and accept flags, a
//   received byte when one completes, and both wrapping byte counters.
//   The frame state and counters are updated at the edge where the input
//   transfer happens, and the result is loaded into an output register at
//   the same edge, so the result appears in the cycle after its tick.
//   Throughput is one tick per cycle: in_ready stays high while the output
//   register is empty or is being drained in the same cycle. When the
//   receiver of the output channel stalls, the held result blocks the next
//   tick, and the frame timing simply pauses with it.
//   Write the bit period via cfg_we/cfg_wdata only while idle; the block does
//   not enforce it. Values below 2 act as 2; the idle poll interval is half that.
//   Reset (synchronous, rst_n low) returns both sequencers to idle, clears the
//   counters, releases the transmit line and sets the bit period to 104.
// ----------------------------------------------------------------------------
module bitbang_uart_transceiver_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [bbuart_pkg::PERIOD_W-1:0]     cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_rx_line_asserted,
  input  logic                                in_send_request,
  input  logic [bbuart_pkg::DATA_BITS-1:0]    in_send_data,
  input  logic                                in_clear_counts,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_tx_line_asserted,
  output logic                                out_tx_busy,
  output logic                                out_send_accepted,
  output logic                                out_rx_valid,
  output logic [bbuart_pkg::DATA_BITS-1:0]    out_rx_data,
  output logic [bbuart_pkg::COUNT_WIDTH-1:0]  out_rx_total,
  output logic [bbuart_pkg::COUNT_WIDTH-1:0]  out_tx_total
);

  localparam int PW = bbuart_pkg::PERIOD_W;
  localparam int DW = bbuart_pkg::DATA_BITS;
  localparam int CW = bbuart_pkg::COUNT_WIDTH;
  localparam int IW = bbuart_pkg::BIT_IDX_W;

  // Configuration register.
  logic [PW-1:0] bit_period_r;

  // Transmit state.
  bbuart_pkg::tx_state_t tx_state_r, tx_state_nxt;
  logic [IW-1:0]  tx_bit_r, tx_bit_nxt;
  logic [DW-1:0]  tx_shift_r, tx_shift_nxt;
  logic [PW-1:0]  tx_timer_r, tx_timer_nxt;
  logic           tx_level_r, tx_level_nxt;

  // Receive state.
  bbuart_pkg::rx_state_t rx_state_r, rx_state_nxt;
  logic [IW-1:0]  rx_bit_r, rx_bit_nxt;
  logic [DW-1:0]  rx_shift_r, rx_shift_nxt;
  logic [PW-1:0]  rx_timer_r, rx_timer_nxt;

  // Byte counters.
  logic [CW-1:0]  rx_count_r, rx_count_nxt;
  logic [CW-1:0]  tx_count_r, tx_count_nxt;

  // Output register.
  logic           out_valid_r;
  logic           out_tx_line_r;
  logic           out_tx_busy_r;
  logic           out_accepted_r;
  logic           out_rx_valid_r;
  logic [DW-1:0]  out_rx_data_r;
  logic [CW-1:0]  out_rx_total_r;
  logic [CW-1:0]  out_tx_total_r;

  logic           in_fire;
  logic [PW-1:0]  period;
  logic [PW-1:0]  half_period;
  logic [PW-1:0]  rx_timer_inc;
  logic           accepted;
  logic           rx_done;
  logic [DW-1:0]  rx_byte;
  logic           tx_mid_idle;

  // A tick is taken whenever the output register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign period      = (bit_period_r < bbuart_pkg::PERIOD_MIN) ? bbuart_pkg::PERIOD_MIN
                                                                : bit_period_r;
  assign half_period = period >> 1;

  // --------------------------------------------------------------------------
  // Transmit: bit timing first, then a new request may start a frame in the
  // same tick in which the previous frame finished.
  // --------------------------------------------------------------------------
  always_comb begin
    tx_state_nxt = tx_state_r;
    tx_bit_nxt   = tx_bit_r;
    tx_shift_nxt = tx_shift_r;
    tx_timer_nxt = tx_timer_r;
    tx_level_nxt = tx_level_r;
    accepted     = 1'b0;

    if (tx_state_r != bbuart_pkg::TX_IDLE) begin
      if (tx_timer_r >= period) begin
        tx_timer_nxt = PW'(1);
        unique case (tx_state_r)
          bbuart_pkg::TX_START: begin
            tx_state_nxt = bbuart_pkg::TX_DATA;
            tx_bit_nxt   = '0;
            tx_level_nxt = ~tx_shift_r[0];
          end
          bbuart_pkg::TX_DATA: begin
            if (tx_bit_r == bbuart_pkg::LAST_BIT) begin
              tx_state_nxt = bbuart_pkg::TX_STOP;
              tx_level_nxt = 1'b0;
            end else begin
              tx_bit_nxt   = tx_bit_r + IW'(1);
              tx_level_nxt = ~tx_shift_r[tx_bit_r + IW'(1)];
            end
          end
          bbuart_pkg::TX_STOP: begin
            tx_state_nxt = bbuart_pkg::TX_IDLE;
            tx_level_nxt = 1'b0;
          end
          default: begin
            tx_state_nxt = bbuart_pkg::TX_IDLE;
            tx_level_nxt = 1'b0;
          end
        endcase
      end else begin
        tx_timer_nxt = tx_timer_r + PW'(1);
      end
    end

    tx_mid_idle = (tx_state_nxt == bbuart_pkg::TX_IDLE);
    if (in_send_request && tx_mid_idle) begin
      accepted     = 1'b1;
      tx_state_nxt = bbuart_pkg::TX_START;
      tx_shift_nxt = in_send_data;
      tx_timer_nxt = PW'(1);
      tx_level_nxt = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Receive: poll at half the period while idle, then sample each data bit
  // one period apart, wait one more period and deliver the byte.
  // --------------------------------------------------------------------------
  assign rx_timer_inc = rx_timer_r + PW'(1);

  always_comb begin
    rx_state_nxt = rx_state_r;
    rx_bit_nxt   = rx_bit_r;
    rx_shift_nxt = rx_shift_r;
    rx_timer_nxt = rx_timer_inc;
    rx_done      = 1'b0;
    rx_byte      = '0;

    unique case (rx_state_r)
      bbuart_pkg::RX_IDLE: begin
        if (rx_timer_inc >= half_period) begin
          rx_timer_nxt = '0;
          if (in_rx_line_asserted) begin
            rx_state_nxt = bbuart_pkg::RX_DATA;
            rx_bit_nxt   = '0;
            rx_shift_nxt = '0;
          end
        end
      end
      bbuart_pkg::RX_DATA: begin
        if (rx_timer_inc >= period) begin
          rx_timer_nxt = '0;
          if (!in_rx_line_asserted) begin
            rx_shift_nxt[rx_bit_r] = 1'b1;
          end
          if (rx_bit_r == bbuart_pkg::LAST_BIT) begin
            rx_state_nxt = bbuart_pkg::RX_WAIT;
          end else begin
            rx_bit_nxt = rx_bit_r + IW'(1);
          end
        end
      end
      bbuart_pkg::RX_WAIT: begin
        if (rx_timer_inc >= period) begin
          rx_timer_nxt = '0;
          rx_done      = 1'b1;
          rx_byte      = rx_shift_r;
          rx_state_nxt = bbuart_pkg::RX_IDLE;
        end
      end
      default: begin
        rx_timer_nxt = '0;
        rx_state_nxt = bbuart_pkg::RX_IDLE;
      end
    endcase
  end

  // A clear zeroes the counters, but a byte moved in the same tick still counts.
  assign tx_count_nxt = (in_clear_counts ? '0 : tx_count_r) + CW'(accepted);
  assign rx_count_nxt = (in_clear_counts ? '0 : rx_count_r) + CW'(rx_done);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= bbuart_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      bit_period_r <= cfg_wdata;
    end
  end

  // State registers advance only on an input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_state_r <= bbuart_pkg::TX_IDLE;
      tx_bit_r   <= '0;
      tx_shift_r <= '0;
      tx_timer_r <= '0;
      tx_level_r <= 1'b0;
      rx_state_r <= bbuart_pkg::RX_IDLE;
      rx_bit_r   <= '0;
      rx_shift_r <= '0;
      rx_timer_r <= '0;
      rx_count_r <= '0;
      tx_count_r <= '0;
    end else if (in_fire) begin
      tx_state_r <= tx_state_nxt;
      tx_bit_r   <= tx_bit_nxt;
      tx_shift_r <= tx_shift_nxt;
      tx_timer_r <= tx_timer_nxt;
      tx_level_r <= tx_level_nxt;
      rx_state_r <= rx_state_nxt;
      rx_bit_r   <= rx_bit_nxt;
      rx_shift_r <= rx_shift_nxt;
      rx_timer_r <= rx_timer_nxt;
      rx_count_r <= rx_count_nxt;
      tx_count_r <= tx_count_nxt;
    end
  end

  // Output register: valid is control, the payload loads with each tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tx_line_r  <= tx_level_nxt;
      out_tx_busy_r  <= (tx_state_nxt != bbuart_pkg::TX_IDLE);
      out_accepted_r <= accepted;
      out_rx_valid_r <= rx_done;
      out_rx_data_r  <= rx_byte;
      out_rx_total_r <= rx_count_nxt;
      out_tx_total_r <= tx_count_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tx_line_asserted = out_tx_line_r;
  assign out_tx_busy          = out_tx_busy_r;
  assign out_send_accepted    = out_accepted_r;
  assign out_rx_valid         = out_rx_valid_r;
  assign out_rx_data          = out_rx_data_r;
  assign out_rx_total         = out_rx_total_r;
  assign out_tx_total         = out_tx_total_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted request starts a frame with the start bit on the line.
  a_accept_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accepted_r) |-> (out_tx_busy_r && out_tx_line_r))
    else $error("accepted send did not start a frame");

  // The received byte field is zero unless a byte is delivered.
  a_rx_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rx_valid_r) |-> (out_rx_data_r == '0))
    else $error("rx_data nonzero without rx_valid");

  // An idle transmitter keeps the line released.
  a_tx_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_state_r == bbuart_pkg::TX_IDLE) |-> !tx_level_r)
    else $error("transmit line asserted while idle");

  // The reported counters match the internal counters after each tick.
  a_totals_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_tx_total_r == tx_count_r) && (out_rx_total_r == rx_count_r))
    else $error("reported totals differ from counters");

  // A busy transmitter always has a running bit timer.
  a_tx_timer_running: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_state_r != bbuart_pkg::TX_IDLE) |-> (tx_timer_r != '0))
    else $error("transmit timer stopped during a frame");

endmodule
